/* rtl/core/csli_pkg.sv */
`default_nettype none

package csli_pkg;

	localparam int SLOTS_DEF    = 16;
	localparam int KEY_BITS_DEF = 64;

	// fixed port widths
	localparam int KEY_W   = 64;
	localparam int INDEX_W = 4;
	localparam int SLOT_W  = 5;

	// reported slot number for "none" / end of list
	localparam logic [SLOT_W-1:0] SLOT_NONE = 5'h1F;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FREE,
		ST_WALK,
		ST_LINK,
		ST_LINK2,
		ST_READ
	} csli_state_t;

	// control from the sequencer to the slot store
	typedef struct packed {
		logic rd_en;
		logic key_we;
		logic link_we;
	} store_ctl_t;

endpackage

`default_nettype wire

/* rtl/core/csli_store.sv */
`default_nettype none

module csli_store #(
	parameter int SLOTS    = csli_pkg::SLOTS_DEF,
	parameter int KEY_BITS = csli_pkg::KEY_BITS_DEF,
	localparam int IW      = $clog2(SLOTS),
	localparam int LW      = IW + 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire csli_pkg::store_ctl_t  ctl,
	input  wire logic [IW-1:0]         rd_addr,
	input  wire logic [IW-1:0]         wr_addr,
	input  wire logic [KEY_BITS-1:0]   wr_key,
	input  wire logic [LW-1:0]         wr_link,
	output logic      [KEY_BITS-1:0]   rd_key,
	output logic      [LW-1:0]         rd_link
);
	import csli_pkg::*;

	// link encoding: msb set means end of list
	logic [KEY_BITS-1:0] key_mem [SLOTS];
	logic [LW-1:0]       link_mem [SLOTS];

	logic [SLOTS-1:0]    key_vld_q;
	logic [SLOTS-1:0]    link_vld_q;

	logic [KEY_BITS-1:0] key_rd_q;
	logic [LW-1:0]       link_rd_q;
	logic                key_hit_q;
	logic                link_hit_q;
	logic [IW-1:0]       raddr_q;
	logic [LW-1:0]       link_rst;

	always_ff @(posedge clk) begin
		if (ctl.key_we) begin
			key_mem[wr_addr] <= wr_key;
		end
		if (ctl.link_we) begin
			link_mem[wr_addr] <= wr_link;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			key_rd_q  <= key_mem[rd_addr];
			link_rd_q <= link_mem[rd_addr];
			raddr_q   <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_vld_q  <= '0;
			link_vld_q <= '0;
			key_hit_q  <= 1'b0;
			link_hit_q <= 1'b0;
		end else begin
			if (ctl.key_we) begin
				key_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.link_we) begin
				link_vld_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				key_hit_q  <= key_vld_q[rd_addr];
				link_hit_q <= link_vld_q[rd_addr];
			end
		end
	end

	// untouched slot i links to i-1, slot 0 to the end
	always_comb begin
		if (raddr_q == '0) begin
			link_rst = {1'b1, {IW{1'b0}}};
		end else begin
			link_rst = {1'b0, raddr_q - IW'(1)};
		end
	end

	assign rd_key  = key_hit_q ? key_rd_q : '0;
	assign rd_link = link_hit_q ? link_rd_q : link_rst;

endmodule

`default_nettype wire

/* rtl/core/cursor_sorted_list_insert_unit.sv */
`default_nettype none

// sorted list of keys kept in a pool of SLOTS slots linked by index.
// command channel: a command transfers when start is high and busy is low.
//   cmd = insert: take the head of the free list and link it into the sorted
//   list in front of the first key not smaller than the new one.
//   cmd = read: report the key and next link of slot index.
// result channel: done is high for one cycle with slot, full_res, slot_key,
//   next_link and list_head; the receiver takes it in that cycle.
// insert steps: pop the free head, walk the list with one slot store read
//   per entry visited (0 to SLOTS - 1 entries), since each next address
//   comes out of the link memory, write the new slot and, when it goes
//   behind another entry, also the link of that entry. read: one slot store
//   read. insert into a full pool, read beyond the pool: no store access.
// a new command is taken as soon as busy is low, also while done
//   shows the previous result.
// after reset the sorted list is empty and the free list hands out the
//   highest slot first; no clearing pass is needed.
module cursor_sorted_list_insert_unit #(
	parameter int SLOTS    = csli_pkg::SLOTS_DEF,
	parameter int KEY_BITS = csli_pkg::KEY_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic                         cmd,
	input  wire logic [csli_pkg::KEY_W-1:0]   key,
	input  wire logic [csli_pkg::INDEX_W-1:0] index,
	output logic                              done,
	output logic      [csli_pkg::SLOT_W-1:0]  slot,
	output logic                              full_res,
	output logic      [csli_pkg::KEY_W-1:0]   slot_key,
	output logic      [csli_pkg::SLOT_W-1:0]  next_link,
	output logic      [csli_pkg::SLOT_W-1:0]  list_head
);
	import csli_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int LW = IW + 1;
	localparam int SW = $clog2(SLOTS + 1);
	localparam logic [LW-1:0] LINK_END = {1'b1, {IW{1'b0}}};

	csli_state_t         state_q, state_d;

	logic [KEY_BITS-1:0] key_q;
	logic [IW-1:0]       fresh_q;
	logic [IW-1:0]       idx_q;
	logic [LW-1:0]       cur_q;
	logic [LW-1:0]       prev_q;
	logic [LW-1:0]       free_q;
	logic [LW-1:0]       head_q;
	logic [SW-1:0]       steps_q;

	store_ctl_t          ctl;
	logic [IW-1:0]       rd_addr;
	logic [IW-1:0]       wr_addr;
	logic [LW-1:0]       wr_link;
	logic [KEY_BITS-1:0] rd_key;
	logic [LW-1:0]       rd_link;

	logic                is_ins;
	logic                idx_ok;
	logic                less;
	logic [SW-1:0]       steps_inc;
	logic                walk_more;

	logic                res_ld;
	logic [SLOT_W-1:0]   res_slot;
	logic                res_full;
	logic [KEY_W-1:0]    res_key;
	logic [SLOT_W-1:0]   res_link;
	logic [SLOT_W-1:0]   res_head;

	function automatic logic [SLOT_W-1:0] enc_link(input logic [LW-1:0] l);
		logic [31:0] w;
		w = 32'(l[IW-1:0]);
		if (l[IW]) begin
			return SLOT_NONE;
		end
		return w[SLOT_W-1:0];
	endfunction

	csli_store #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_key  (key_q),
		.wr_link (wr_link),
		.rd_key  (rd_key),
		.rd_link (rd_link)
	);

	assign busy      = (state_q != ST_IDLE);
	assign is_ins    = (cmd == CMD_INSERT);
	assign idx_ok    = (32'(index) < SLOTS);
	assign less      = (rd_key < key_q);
	assign steps_inc = steps_q + SW'(1);
	// keep walking while the current key is smaller, the next entry exists and the walk bound allows it
	assign walk_more = less && !rd_link[IW] && (steps_inc < SW'(SLOTS));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (is_ins) begin
						if (!free_q[IW]) begin
							state_d = ST_FREE;
						end
					end else if (idx_ok) begin
						state_d = ST_READ;
					end
				end
			end
			ST_FREE: begin
				state_d = head_q[IW] ? ST_LINK : ST_WALK;
			end
			ST_WALK: begin
				state_d = walk_more ? ST_WALK : ST_LINK;
			end
			ST_LINK: begin
				state_d = prev_q[IW] ? ST_IDLE : ST_LINK2;
			end
			ST_LINK2: begin
				state_d = ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl      = '0;
		rd_addr  = '0;
		wr_addr  = fresh_q;
		wr_link  = cur_q;
		res_ld   = 1'b0;
		res_slot = SLOT_NONE;
		res_full = 1'b0;
		res_key  = '0;
		res_link = SLOT_NONE;
		res_head = enc_link(head_q);
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (is_ins) begin
						// fetch the free head's link to pop it
						rd_addr   = free_q[IW-1:0];
						ctl.rd_en = !free_q[IW];
						res_ld    = free_q[IW];
						res_full  = 1'b1;
					end else begin
						rd_addr   = IW'(index);
						ctl.rd_en = idx_ok;
						res_ld    = !idx_ok;
					end
				end
			end
			ST_FREE: begin
				rd_addr   = head_q[IW-1:0];
				ctl.rd_en = !head_q[IW];
			end
			ST_WALK: begin
				rd_addr   = rd_link[IW-1:0];
				ctl.rd_en = walk_more;
			end
			ST_LINK: begin
				ctl.key_we  = 1'b1;
				ctl.link_we = 1'b1;
				wr_addr     = fresh_q;
				wr_link     = cur_q;
				res_ld      = prev_q[IW];
				res_slot    = enc_link({1'b0, fresh_q});
				res_key     = KEY_W'(key_q);
				res_link    = enc_link(cur_q);
				res_head    = enc_link({1'b0, fresh_q});
			end
			ST_LINK2: begin
				ctl.link_we = 1'b1;
				wr_addr     = prev_q[IW-1:0];
				wr_link     = {1'b0, fresh_q};
				res_ld      = 1'b1;
				res_slot    = enc_link({1'b0, fresh_q});
				res_key     = KEY_W'(key_q);
				res_link    = enc_link(cur_q);
			end
			ST_READ: begin
				res_ld   = 1'b1;
				res_slot = enc_link({1'b0, idx_q});
				res_key  = KEY_W'(rd_key);
				res_link = enc_link(rd_link);
			end
			default: begin
				res_ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			free_q  <= {1'b0, IW'(SLOTS - 1)};
			head_q  <= LINK_END;
			cur_q   <= LINK_END;
			prev_q  <= LINK_END;
			steps_q <= '0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= res_ld;
			unique case (state_q)
				ST_IDLE: begin
					prev_q  <= LINK_END;
					steps_q <= '0;
				end
				ST_FREE: begin
					free_q <= rd_link;
					cur_q  <= head_q;
				end
				ST_WALK: begin
					if (less) begin
						prev_q  <= cur_q;
						cur_q   <= rd_link;
						steps_q <= steps_inc;
					end
				end
				ST_LINK: begin
					if (prev_q[IW]) begin
						head_q <= {1'b0, fresh_q};
					end
				end
				ST_LINK2, ST_READ: begin
					steps_q <= steps_q;
				end
				default: begin
					steps_q <= steps_q;
				end
			endcase
		end
	end

	// command and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			key_q   <= key[KEY_BITS-1:0];
			fresh_q <= free_q[IW-1:0];
			idx_q   <= IW'(index);
		end
		if (res_ld) begin
			slot      <= res_slot;
			full_res  <= res_full;
			slot_key  <= res_key;
			next_link <= res_link;
			list_head <= res_head;
		end
	end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
	import csli_pkg::*;

	localparam int LIST_SLOTS = SLOTS_DEF;
	localparam int GAP_MAX    = 4;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		logic              full;
		logic [KEY_W-1:0]  skey;
		logic [SLOT_W-1:0] nlink;
		logic [SLOT_W-1:0] head;
	} list_result_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                cmd;
	logic [KEY_W-1:0]    key;
	logic [INDEX_W-1:0]  index;
	logic                done;
	logic [SLOT_W-1:0]   slot;
	logic                full_res;
	logic [KEY_W-1:0]    slot_key;
	logic [SLOT_W-1:0]   next_link;
	logic [SLOT_W-1:0]   list_head;

	// own copy of the slot pool
	logic [KEY_W-1:0]  pool_key[LIST_SLOTS];
	logic [SLOT_W-1:0] pool_link[LIST_SLOTS];
	logic [SLOT_W-1:0] free_ptr;
	logic [SLOT_W-1:0] head_ptr;
	logic [SLOT_W-1:0] walk_pos;

	list_result_t pending_results[$];
	int           idle_pct;
	int           error_count;
	int           checked_count;
	int           placed_count;
	int           dropped_count;
	int           read_count;

	cursor_sorted_list_insert_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.key       (key),
		.index     (index),
		.done      (done),
		.slot      (slot),
		.full_res  (full_res),
		.slot_key  (slot_key),
		.next_link (next_link),
		.list_head (list_head)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#500000;
		$display("tb_top: errors");
		$finish;
	end

	function automatic logic in_pool(input logic [SLOT_W-1:0] s);
		return !s[SLOT_W-1];
	endfunction

	task automatic reset_pool_copy;
		for (int i = 0; i < LIST_SLOTS; i++) begin
			pool_key[i]  = '0;
			pool_link[i] = (i == 0) ? SLOT_NONE : SLOT_W'(i - 1);
		end
		free_ptr = SLOT_W'(LIST_SLOTS - 1);
		head_ptr = SLOT_NONE;
		walk_pos = SLOT_NONE;
	endtask

	function automatic list_result_t predict_list_result(input logic c,
			input logic [KEY_W-1:0] k, input logic [INDEX_W-1:0] ix);
		list_result_t      r;
		logic [SLOT_W-1:0] fresh;
		logic [SLOT_W-1:0] prev;
		logic [SLOT_W-1:0] cur;
		int                steps;
		r.slot  = SLOT_NONE;
		r.full  = 1'b0;
		r.skey  = '0;
		r.nlink = SLOT_NONE;
		if (c == CMD_INSERT) begin
			if (in_pool(free_ptr)) begin
				fresh    = free_ptr;
				prev     = SLOT_NONE;
				cur      = head_ptr;
				steps    = 0;
				free_ptr = pool_link[fresh];
				// stop at the first key not smaller, so ties go in front
				while (in_pool(cur) && steps < LIST_SLOTS && pool_key[cur] < k) begin
					prev = cur;
					cur  = pool_link[cur];
					steps++;
				end
				if (!in_pool(cur))
					cur = SLOT_NONE;
				pool_key[fresh]  = k;
				pool_link[fresh] = cur;
				if (prev == SLOT_NONE)
					head_ptr = fresh;
				else
					pool_link[prev] = fresh;
				r.slot  = fresh;
				r.skey  = k;
				r.nlink = cur;
				placed_count++;
			end else begin
				r.full = 1'b1;
				dropped_count++;
			end
		end else begin
			r.slot  = SLOT_W'(ix);
			r.skey  = pool_key[ix];
			r.nlink = pool_link[ix];
			read_count++;
		end
		r.head = head_ptr;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= 60)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [KEY_W-1:0] got,
			input logic [KEY_W-1:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing outstanding, slot %h", slot));
			end else begin
				want = pending_results.pop_front();
				check_field("slot", KEY_W'(slot), KEY_W'(want.slot));
				check_field("full_res", KEY_W'(full_res), KEY_W'(want.full));
				check_field("slot_key", slot_key, want.skey);
				check_field("next_link", KEY_W'(next_link), KEY_W'(want.nlink));
				check_field("list_head", KEY_W'(list_head), KEY_W'(want.head));
				checked_count++;
			end
		end
	end

	// one command transfer, with an occasional sender gap in front of it
	task automatic send_command(input logic c, input logic [KEY_W-1:0] k,
			input logic [INDEX_W-1:0] ix);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		key   <= k;
		index <= ix;
		do @(posedge clk); while (busy);
		pending_results.push_back(predict_list_result(c, k, ix));
	endtask

	task automatic drain_results;
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	function automatic logic [KEY_W-1:0] pick_key;
		logic [KEY_W-1:0] v;
		int               len;
		v = '0;
		case ($urandom_range(0, 5))
			0: v = '1;
			1: v = '0;
			2: v = {$urandom, $urandom};
			3: begin
				// short lower-case word, big-endian, zero padded
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++)
					v[KEY_W-1-8*i -: 8] = 8'($urandom_range(97, 122));
			end
			4: v = pool_key[$urandom_range(0, LIST_SLOTS - 1)];
			default: v = {$urandom, $urandom} >> $urandom_range(0, KEY_W - 1);
		endcase
		return v;
	endfunction

	task automatic test_reset_state;
		send_command(CMD_READ, '0, INDEX_W'(0));
		send_command(CMD_READ, '1, INDEX_W'(LIST_SLOTS - 1));
		send_command(CMD_READ, {$urandom, $urandom}, INDEX_W'(8));
	endtask

	task automatic test_insert_order;
		send_command(CMD_INSERT, '1, INDEX_W'(0));
		send_command(CMD_INSERT, '0, '1);
		// equal key lands in front of the older one
		send_command(CMD_INSERT, '1, INDEX_W'(5));
		send_command(CMD_INSERT, 64'h4142_0000_0000_0000, INDEX_W'(0));
		send_command(CMD_INSERT, 64'h4142_0000_0000_0001, INDEX_W'(0));
		send_command(CMD_READ, '0, INDEX_W'(LIST_SLOTS - 1));
		send_command(CMD_READ, '0, INDEX_W'(LIST_SLOTS - 3));
		send_command(CMD_READ, '0, INDEX_W'(LIST_SLOTS - 5));
		drain_results();
	endtask

	task automatic test_random_traffic(input int count);
		logic [INDEX_W-1:0] ix;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(0, 99) < 5) begin
				send_command(CMD_INSERT, pick_key(), INDEX_W'($urandom));
			end else begin
				ix = INDEX_W'($urandom);
				// half the reads walk the sorted list in order
				if ($urandom_range(0, 1) == 1) begin
					if (!in_pool(walk_pos))
						walk_pos = head_ptr;
					if (in_pool(walk_pos)) begin
						ix       = walk_pos[INDEX_W-1:0];
						walk_pos = pool_link[walk_pos];
					end
				end
				send_command(CMD_READ, {$urandom, $urandom}, ix);
			end
		end
	endtask

	task automatic test_pool_full;
		while (in_pool(free_ptr))
			send_command(CMD_INSERT, pick_key(), INDEX_W'($urandom));
		send_command(CMD_INSERT, '1, '1);
		send_command(CMD_INSERT, {$urandom, $urandom}, INDEX_W'($urandom));
		send_command(CMD_READ, '0, head_ptr[INDEX_W-1:0]);
	endtask

	initial begin
		arst_n        <= 1'b0;
		start         <= 1'b0;
		cmd           <= CMD_INSERT;
		key           <= '0;
		index         <= '0;
		error_count   = 0;
		checked_count = 0;
		placed_count  = 0;
		dropped_count = 0;
		read_count    = 0;
		idle_pct      = 6;
		reset_pool_copy();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_insert_order();
		test_random_traffic(260);
		idle_pct = 66;
		test_random_traffic(260);
		idle_pct = 0;
		test_random_traffic(260);
		test_pool_full();

		drain_results();
		repeat (32) @(posedge clk);
		$display("covered %0d inserts placed, %0d dropped on a full pool, %0d slot reads",
			placed_count, dropped_count, read_count);
		$display("%0d results compared, %0d mismatches", checked_count, error_count);
		if (error_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule
